@@ hdl/calibration_polynomial_eval_macros.svh @@
// assertion macros for the calibration polynomial evaluator
// used by the top level; expects clk and rst_n in scope
`ifndef CALIBRATION_POLYNOMIAL_EVAL_MACROS_SVH
`define CALIBRATION_POLYNOMIAL_EVAL_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cpe_pkg.sv @@
// shared types and constants for the calibration polynomial evaluator
// no dependencies; used by cpe_horner_step and calibration_polynomial_eval
package cpe_pkg;

    localparam int unsigned MAX_DEGREE_DEF = 8;
    localparam int unsigned NUM_COEF       = 9;
    localparam int unsigned DEG_W          = 4;
    localparam int unsigned COEF_W         = 32;
    localparam int unsigned ACC_W          = 48;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_AB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_EF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_GH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_I  = 3'd5;

    typedef logic signed [COEF_W-1:0] coef_t;

    // one sample in flight through the horner chain
    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic                    ovf;
        logic [DEG_W-1:0]        degree;
        logic [COEF_W-1:0]       x_mag;
        logic                    x_neg;
        logic signed [ACC_W-1:0] acc;
    } item_t;

endpackage

@@ hdl/calibration_polynomial_eval.sv @@
// top level of the calibration polynomial evaluator (pipelined horner, Q16.16)
// depends on cpe_pkg, cpe_horner_step and calibration_polynomial_eval_macros.svh
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | sample_x
//   out     | output    | out_valid / out_stall| calibrated_y, overflow
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one request per cycle while in_stall is low; each horner step is four stages
// (abs, 24x32 multiply pair, recombine, signed add and saturate), and a
// result passes the entry register, every horner step, the final saturation
// register and the output register in that order, for any configured degree.
// reset clears valid bits and the configuration (degree 1, coefficients zero).
// the output register has a one-entry skid stage; in_stall rises only when
// the skid stage is full, and then the whole chain holds.
`include "calibration_polynomial_eval_macros.svh"

module calibration_polynomial_eval
    import cpe_pkg::*;
#(
    parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      sample_x,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      calibrated_y,
    output logic                    overflow,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [DEG_W-1:0] degree_reg;
    coef_t            coef_reg [NUM_COEF];

    item_t            entry_next;
    item_t            entry_reg;
    item_t            chain [MAX_DEGREE+1];
    coef_t            top_coef;
    logic             deg_ok;
    logic             advance;

    logic             fin_valid_reg, fin_ovf_reg;
    logic [31:0]      fin_y_reg;
    logic [31:0]      fin_y_next;
    logic             fin_ovf_next;
    item_t            tail;

    logic             out_valid_reg, out_ovf_reg;
    logic [31:0]      out_y_reg;
    logic             skid_full_reg, skid_ovf_reg;
    logic [31:0]      skid_y_reg;
    logic             out_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEG_W'(1);
            for (int k = 0; k < NUM_COEF; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEGREE:  degree_reg <= cfg_data[DEG_W-1:0];
                REG_COEF_AB:
                begin
                    coef_reg[0] <= cfg_data[31:0];
                    coef_reg[1] <= cfg_data[63:32];
                end
                REG_COEF_CD:
                begin
                    coef_reg[2] <= cfg_data[31:0];
                    coef_reg[3] <= cfg_data[63:32];
                end
                REG_COEF_EF:
                begin
                    coef_reg[4] <= cfg_data[31:0];
                    coef_reg[5] <= cfg_data[63:32];
                end
                REG_COEF_GH:
                begin
                    coef_reg[6] <= cfg_data[31:0];
                    coef_reg[7] <= cfg_data[63:32];
                end
                REG_COEF_I:  coef_reg[8] <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // chain moves unless the skid stage holds a result
    assign advance  = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // entry: seed accumulator with the top coefficient, take |x|
    always_comb
    begin
        deg_ok   = (degree_reg != '0) && (degree_reg <= DEG_W'(MAX_DEGREE));
        top_coef = '0;
        for (int k = 0; k < NUM_COEF; k++)
        begin
            if (degree_reg == DEG_W'(k))
            begin
                top_coef = coef_reg[k];
            end
        end
        entry_next.valid  = in_valid;
        entry_next.zero   = !deg_ok;
        entry_next.ovf    = 1'b0;
        entry_next.degree = degree_reg;
        entry_next.x_mag  = sample_x[31] ? (~sample_x + 32'sd1) : sample_x;
        entry_next.x_neg  = sample_x[31];
        entry_next.acc    = {{(ACC_W-COEF_W){top_coef[COEF_W-1]}}, top_coef};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    assign chain[0] = entry_reg;

    // horner steps, highest lower coefficient first
    for (genvar j = 0; j < MAX_DEGREE; j++)
    begin : g_step
        cpe_horner_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .coef_idx (DEG_W'(MAX_DEGREE - 1 - j)),
            .coef     (coef_reg[MAX_DEGREE - 1 - j]),
            .item_in  (chain[j]),
            .item_out (chain[j+1])
        );
    end

    assign tail = chain[MAX_DEGREE];

    // final saturation to Q16.16
    always_comb
    begin
        fin_y_next   = tail.acc[31:0];
        fin_ovf_next = tail.ovf;
        if (tail.zero)
        begin
            fin_y_next   = '0;
            fin_ovf_next = 1'b0;
        end
        else if (!tail.acc[ACC_W-1] && (|tail.acc[ACC_W-2:31]))
        begin
            fin_y_next   = 32'h7FFF_FFFF;
            fin_ovf_next = 1'b1;
        end
        else if (tail.acc[ACC_W-1] && !(&tail.acc[ACC_W-2:31]))
        begin
            fin_y_next   = 32'h8000_0000;
            fin_ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fin_valid_reg <= tail.valid;
            fin_y_reg     <= fin_y_next;
            fin_ovf_reg   <= fin_ovf_next;
        end
    end

    // output register with one-entry skid stage
    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_fire)
            begin
                out_y_reg     <= skid_y_reg;
                out_ovf_reg   <= skid_ovf_reg;
                skid_full_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= fin_valid_reg;
            out_y_reg     <= fin_y_reg;
            out_ovf_reg   <= fin_ovf_reg;
        end
        else if (fin_valid_reg)
        begin
            skid_y_reg    <= fin_y_reg;
            skid_ovf_reg  <= fin_ovf_reg;
            skid_full_reg <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign calibrated_y = out_y_reg;
    assign overflow     = out_ovf_reg;

    // checks
    `CPE_ASSERT_IMPL(a_skid_needs_out, skid_full_reg, out_valid_reg, "skid full without output")
    `CPE_ASSERT_NEXT(a_skid_holds, skid_full_reg && out_stall, skid_full_reg, "skid entry lost")
    `CPE_ASSERT_NEXT(a_tail_frozen, skid_full_reg,
        $stable(fin_valid_reg) && $stable(fin_y_reg) && $stable(fin_ovf_reg),
        "chain moved while skid full")

endmodule

@@ hdl/cpe_horner_step.sv @@
// one horner step: acc = sat48(trunc(acc * x / 2^16) + coef), four stages
// depends on cpe_pkg
module cpe_horner_step
    import cpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [DEG_W-1:0] coef_idx,
    input  coef_t            coef,
    input  item_t            item_in,
    output item_t            item_out
);

    item_t             s1_reg, s2_reg, s3_reg, s4_reg;
    logic [ACC_W-1:0]  s1_mag_reg;
    logic              s1_neg_reg;
    logic [55:0]       s2_hi_reg, s2_lo_reg;
    logic              s2_neg_reg;
    logic [63:0]       s3_mag_reg;
    logic              s3_neg_reg;

    logic [ACC_W-1:0]  s1_mag_next;
    logic [55:0]       s2_hi_next, s2_lo_next;
    logic [63:0]       s3_mag_next;
    logic [64:0]       sum;
    logic              sat_pos, sat_neg, active;
    item_t             s4_next;

    // stage 1: accumulator magnitude
    assign s1_mag_next = item_in.acc[ACC_W-1] ? (~item_in.acc + 48'd1) : item_in.acc;

    // stage 2: split 48 x 32 magnitude product into two 24 x 32 partials
    assign s2_hi_next = 56'(s1_mag_reg[47:24]) * 56'(s1_reg.x_mag);
    assign s2_lo_next = 56'(s1_mag_reg[23:0]) * 56'(s1_reg.x_mag);

    // stage 3: recombine, dropping 16 fraction bits (truncates the magnitude)
    assign s3_mag_next = {s2_hi_reg, 8'b0} + 64'(s2_lo_reg[55:16]);

    // stage 4: apply sign, add coefficient, saturate to 48 bits; steps above the degree pass acc through
    always_comb
    begin
        sum     = ({1'b0, s3_mag_reg} ^ {65{s3_neg_reg}}) + 65'(s3_neg_reg)
                  + {{33{coef[COEF_W-1]}}, coef};
        sat_pos = !sum[64] && (|sum[63:47]);
        sat_neg = sum[64] && !(&sum[63:47]);
        active  = !s3_reg.zero && (s3_reg.degree > coef_idx);
        s4_next = s3_reg;
        if (active)
        begin
            if (sat_pos)
            begin
                s4_next.acc = {1'b0, {(ACC_W-1){1'b1}}};
                s4_next.ovf = 1'b1;
            end
            else if (sat_neg)
            begin
                s4_next.acc = {1'b1, {(ACC_W-1){1'b0}}};
                s4_next.ovf = 1'b1;
            end
            else
            begin
                s4_next.acc = sum[47:0];
            end
        end
    end

    // stage registers, all moving together on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
            s4_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            s1_reg     <= item_in;
            s1_mag_reg <= s1_mag_next;
            s1_neg_reg <= item_in.acc[ACC_W-1] ^ item_in.x_neg;
            s2_reg     <= s1_reg;
            s2_hi_reg  <= s2_hi_next;
            s2_lo_reg  <= s2_lo_next;
            s2_neg_reg <= s1_neg_reg;
            s3_reg     <= s2_reg;
            s3_mag_reg <= s3_mag_next;
            s3_neg_reg <= s2_neg_reg;
            s4_reg     <= s4_next;
        end
    end

    assign item_out = s4_reg;

endmodule

@@ tb/calib_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// expected-result tracking for the calibration polynomial evaluator bench
// depends on cpe_pkg for the register indexes, coefficient type and widths
package calib_scoreboard_pkg;

    import cpe_pkg::*;

    typedef struct {
        logic signed [31:0] y;
        logic               ovf;
    } calib_result_t;

    // 48-bit accumulator and 32-bit output limits, held in a wide signed form
    localparam logic signed [65:0] ACC_HI = 66'sh7FFF_FFFF_FFFF;
    localparam logic signed [65:0] ACC_LO = -66'sh8000_0000_0000;
    localparam logic signed [65:0] OUT_HI = 66'sh7FFF_FFFF;
    localparam logic signed [65:0] OUT_LO = -66'sh8000_0000;

    class calib_scoreboard;

        logic [DEG_W-1:0] degree;
        coef_t            coef[NUM_COEF];
        calib_result_t    pending_results[$];
        int unsigned      errors;

        function new();
            degree = 4'd1;
            foreach (coef[k])
                coef[k] = '0;
            errors = 0;
        endfunction

        // mirror one register write; unknown indexes are dropped
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEGREE:  degree = data[DEG_W-1:0];
                REG_COEF_AB:
                begin
                    coef[0] = data[31:0];
                    coef[1] = data[63:32];
                end
                REG_COEF_CD:
                begin
                    coef[2] = data[31:0];
                    coef[3] = data[63:32];
                end
                REG_COEF_EF:
                begin
                    coef[4] = data[31:0];
                    coef[5] = data[63:32];
                end
                REG_COEF_GH:
                begin
                    coef[6] = data[31:0];
                    coef[7] = data[63:32];
                end
                REG_COEF_I:  coef[8] = data[31:0];
                default:     ;
            endcase
        endfunction

        // horner chain: acc = trunc(acc * x / 2^16) + coef, 48-bit saturation, 32-bit output clamp
        function calib_result_t eval_polynomial(logic signed [31:0] x);
            calib_result_t     r;
            logic signed [65:0] acc;
            logic signed [65:0] term;
            logic [79:0]        prod;
            logic [47:0]        acc_mag;
            logic [31:0]        x_mag;
            logic               neg;
            int                 k;
            r.y = '0;
            r.ovf = 1'b0;
            if (degree == 0 || degree > MAX_DEGREE_DEF)
                return r;
            acc = coef[degree];
            for (k = int'(degree) - 1; k >= 0; k--)
            begin
                neg = acc[65] ^ x[31];
                acc_mag = acc[65] ? 48'(-acc) : acc[47:0];
                x_mag = x[31] ? -x : x;
                // magnitude product, truncated toward zero by the shift
                prod = {32'd0, acc_mag} * {48'd0, x_mag};
                term = $signed({2'b00, prod[79:16]});
                acc = (neg ? -term : term) + coef[k];
                if (acc > ACC_HI)
                begin
                    acc = ACC_HI;
                    r.ovf = 1'b1;
                end
                if (acc < ACC_LO)
                begin
                    acc = ACC_LO;
                    r.ovf = 1'b1;
                end
            end
            if (acc > OUT_HI)
            begin
                acc = OUT_HI;
                r.ovf = 1'b1;
            end
            if (acc < OUT_LO)
            begin
                acc = OUT_LO;
                r.ovf = 1'b1;
            end
            r.y = acc[31:0];
            return r;
        endfunction

        function void note_sample(logic signed [31:0] x);
            pending_results.push_back(eval_polynomial(x));
        endfunction

        function void check_result(logic signed [31:0] y, logic ovf);
            calib_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: y=%h ovf=%b", y, ovf);
                return;
            end
            want = pending_results.pop_front();
            if (want.y !== y || want.ovf !== ovf)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected y=%h ovf=%b, got y=%h ovf=%b",
                             want.y, want.ovf, y, ovf);
            end
        endfunction

    endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// stimulus and checking for calibration_polynomial_eval
// depends on cpe_pkg, calib_scoreboard_pkg and the block's rtl
module testbench;

    import cpe_pkg::*;
    import calib_scoreboard_pkg::*;

    // indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4 * MAX_DEGREE_DEF + 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [31:0]    sample_x;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    calibrated_y;
    logic                  overflow;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    calib_scoreboard board;
    int              hold_cycles;
    bit              steady;
    int              quiet_cycles;

    calibration_polynomial_eval i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_x     (sample_x),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .calibrated_y (calibrated_y),
        .overflow     (overflow),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls, a counted hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= !steady && ($urandom_range(0, 99) < 32);
        end
    end

    // request/result capture and no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_sample(sample_x);
            if (out_valid && !out_stall)
                board.check_result(calibrated_y, overflow);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // random Q16.16 word: extremes, small and mid magnitudes, or any pattern
    function automatic logic [31:0] random_q16();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0:       w = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h0000_0000;
            1, 2, 3, 4: w = $urandom_range(0, 32'h3FFFF);
            5, 6:    w = $urandom_range(0, 32'hFFFFF);
            default: w = $urandom();
        endcase
        if ($urandom_range(0, 1) != 0)
            w = -w;
        return w;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_register(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all(logic [3:0] deg, logic [31:0] c[NUM_COEF]);
        write_register(REG_DEGREE, {60'd0, deg});
        write_register(REG_COEF_AB, {c[1], c[0]});
        write_register(REG_COEF_CD, {c[3], c[2]});
        write_register(REG_COEF_EF, {c[5], c[4]});
        write_register(REG_COEF_GH, {c[7], c[6]});
        write_register(REG_COEF_I, {32'd0, c[8]});
    endtask

    // offer one request, idling at random first, and wait for acceptance
    task automatic send_sample(logic signed [31:0] x);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_x <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and let every outstanding result arrive
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(int count, bit with_hold);
        logic [31:0]       c[NUM_COEF];
        logic [3:0]        deg;
        logic [CFG_DATA_W-1:0] deg_word;
        int                n;
        if ($urandom_range(0, 7) == 0)
            deg = 4'($urandom_range(0, 15));
        else
            deg = 4'($urandom_range(1, MAX_DEGREE_DEF));
        foreach (c[k])
            c[k] = random_q16();
        write_all(deg, c);
        // degree again with junk above the decoded bits
        deg_word = {$urandom(), $urandom()};
        deg_word[3:0] = deg;
        write_register(REG_DEGREE, deg_word);
        for (n = 0; n < count; n++)
        begin
            if (with_hold && n == 30)
                hold_cycles = HOLD_CYCLES;
            send_sample(random_q16());
        end
        wait_drained();
    endtask

    initial
    begin
        logic [31:0] c[NUM_COEF];
        int          p;
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample_x    = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_DEGREE;
        cfg_data    = '0;
        hold_cycles = 0;
        steady      = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: degree one, all coefficients zero
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        wait_drained();

        // full degree, unit coefficients, extremes of x
        foreach (c[k])
            c[k] = 32'h0001_0000;
        write_all(4'd8, c);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        wait_drained();

        // degree zero forces a zero result
        write_register(REG_DEGREE, 64'd0);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h1234_5678);
        wait_drained();

        // final clamp to 32 bits; spare indexes must leave the setup alone
        write_register(REG_DEGREE, 64'd1);
        write_register(REG_COEF_AB, {32'h0001_0000, 32'h7FFF_FFFF});
        write_register(REG_SPARE_6, '1);
        write_register(REG_SPARE_7, '1);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        send_sample(32'h8000_0000);
        wait_drained();

        // degrees past the maximum behave like degree zero
        write_register(REG_DEGREE, 64'd9);
        send_sample(32'h0001_0000);
        wait_drained();
        write_register(REG_DEGREE, 64'd15);
        send_sample(32'h8000_0000);
        wait_drained();

        // most negative coefficients: intermediate 48-bit saturation
        foreach (c[k])
            c[k] = 32'h8000_0000;
        write_all(4'd8, c);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0002_0000);
        wait_drained();

        // random phases; one with no idling, one with a long receiver hold-off
        for (p = 0; p < 12; p++)
        begin
            steady = (p == 2);
            run_random_phase(150, p == 5);
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
